>>> rtl/shortest_path_counter_assert.svh
// Assertion macros shared by the shortest path counter RTL.
// Included by the modules that check their own control logic.
`ifndef SHORTEST_PATH_COUNTER_ASSERT_SVH
`define SHORTEST_PATH_COUNTER_ASSERT_SVH
// Same-cycle implication, disabled while reset is low.
`define SPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/spc_pkg.sv
// Shared types, constants and helpers for the shortest path counter.
// Used by spc_heap and shortest_path_counter; depends on nothing.
`timescale 1ns / 1ps
package spc_pkg;

  localparam int DIST_W   = 57;
  localparam int CNT_W    = 30;
  localparam int VFIELD_W = 10;
  localparam int WEIGHT_W = 32;
  localparam int CFG_W    = 11;

  localparam logic [DIST_W-1:0] NO_PATH   = 57'd100000000000000000;
  localparam logic [CNT_W-1:0]  COUNT_MOD = 30'd1000000007;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [VFIELD_W-1:0] first_vertex;
    logic [VFIELD_W-1:0] second_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  path_count;
    logic              reachable;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] best_dist;
    logic [CNT_W-1:0]  count;
    logic              settled;
  } vert_ent_t;

  typedef struct packed {
    logic start;
    logic push;
  } heap_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic empty;
  } heap_rsp_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_POP_RD,
    H_DN_RD,
    H_DN_CMP,
    H_UP_RD,
    H_UP_CMP
  } heap_state_t;

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_DECODE,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_QRY,
    S_RUN_PUSH,
    S_PUSH0_WAIT,
    S_POP,
    S_POP_WAIT,
    S_CHK_U,
    S_HEAD,
    S_ARC,
    S_ARC_D,
    S_RELAX,
    S_PUSH_WAIT,
    S_RESP
  } top_state_t;

  function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, COUNT_MOD}) begin
      s = s - {1'b0, COUNT_MOD};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

>>> rtl/spc_heap.sv
// Binary min-heap over (key, node) pairs held in one dual-read memory.
// Depends on spc_pkg and shortest_path_counter_assert.svh.
`timescale 1ns / 1ps
`include "shortest_path_counter_assert.svh"
module spc_heap #(
  parameter int MAX_ARCS = 4096,
  parameter int NODE_W   = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spc_pkg::heap_req_t         req,
  input  logic [spc_pkg::DIST_W-1:0] push_key,
  input  logic [NODE_W-1:0]          push_node,
  output spc_pkg::heap_rsp_t         rsp,
  output logic [spc_pkg::DIST_W-1:0] pop_key,
  output logic [NODE_W-1:0]          pop_node
);

  localparam int HDEPTH = MAX_ARCS + 1;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int HW     = $clog2(HDEPTH + 1);
  localparam int KW     = spc_pkg::DIST_W;
  localparam int EW     = KW + NODE_W;

  spc_pkg::heap_state_t state_r, state_nxt;
  logic [HW-1:0]     fill_r;
  logic [HW-1:0]     pos_r;
  logic [KW-1:0]     item_key_r;
  logic [NODE_W-1:0] item_node_r;
  logic [KW-1:0]     out_key_r;
  logic [NODE_W-1:0] out_node_r;
  logic              done_r;

  logic [EW-1:0] heap_mem [HDEPTH];
  logic [EW-1:0] rd_a_r, rd_b_r;
  logic [HAW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic           wr_en;
  logic [EW-1:0]  wr_data;

  logic [KW-1:0]     a_key, b_key, min_key;
  logic [NODE_W-1:0] a_node, b_node, min_node;
  logic [HW:0]       child_l, child_r;
  logic              l_ok, r_ok, take_l, take_r, up_less, push_ok;
  logic [HW-1:0]     parent;
  logic [EW-1:0]     item_ent;

  function automatic logic pair_lt(input logic [KW-1:0] k1, input logic [NODE_W-1:0] n1,
                                   input logic [KW-1:0] k2, input logic [NODE_W-1:0] n2);
    return (k1 < k2) || ((k1 == k2) && (n1 < n2));
  endfunction

  assign a_key    = rd_a_r[EW-1:NODE_W];
  assign a_node   = rd_a_r[NODE_W-1:0];
  assign b_key    = rd_b_r[EW-1:NODE_W];
  assign b_node   = rd_b_r[NODE_W-1:0];
  assign item_ent = {item_key_r, item_node_r};
  assign child_l  = {pos_r, 1'b1};
  assign child_r  = child_l + (HW+1)'(1);
  assign l_ok     = child_l < {1'b0, fill_r};
  assign r_ok     = child_r < {1'b0, fill_r};
  assign take_l   = l_ok && pair_lt(a_key, a_node, item_key_r, item_node_r);
  assign min_key  = take_l ? a_key : item_key_r;
  assign min_node = take_l ? a_node : item_node_r;
  assign take_r   = r_ok && pair_lt(b_key, b_node, min_key, min_node);
  assign parent   = (pos_r - HW'(1)) >> 1;
  assign up_less  = pair_lt(item_key_r, item_node_r, a_key, a_node);
  assign push_ok  = fill_r != HW'(HDEPTH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spc_pkg::H_IDLE: begin
        if (req.start) begin
          if (!req.push) begin
            state_nxt = spc_pkg::H_POP_RD;
          end else if (push_ok) begin
            state_nxt = spc_pkg::H_UP_RD;
          end
        end
      end
      spc_pkg::H_POP_RD: begin
        state_nxt = (fill_r == '0) ? spc_pkg::H_IDLE : spc_pkg::H_DN_RD;
      end
      spc_pkg::H_DN_RD: state_nxt = spc_pkg::H_DN_CMP;
      spc_pkg::H_DN_CMP: begin
        state_nxt = (take_l || take_r) ? spc_pkg::H_DN_RD : spc_pkg::H_IDLE;
      end
      spc_pkg::H_UP_RD: begin
        state_nxt = (pos_r == '0) ? spc_pkg::H_IDLE : spc_pkg::H_UP_CMP;
      end
      spc_pkg::H_UP_CMP: begin
        state_nxt = up_less ? spc_pkg::H_UP_RD : spc_pkg::H_IDLE;
      end
      default: state_nxt = spc_pkg::H_IDLE;
    endcase
  end

  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = HAW'(fill_r - HW'(1));
    wr_en     = 1'b0;
    wr_addr   = pos_r[HAW-1:0];
    wr_data   = item_ent;
    case (state_r)
      spc_pkg::H_DN_RD: begin
        rd_a_addr = child_l[HAW-1:0];
        rd_b_addr = child_r[HAW-1:0];
      end
      spc_pkg::H_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_b_r;
        end else if (take_l) begin
          wr_data = rd_a_r;
        end
      end
      spc_pkg::H_UP_RD: begin
        rd_a_addr = parent[HAW-1:0];
        wr_en     = (pos_r == '0);
      end
      spc_pkg::H_UP_CMP: begin
        wr_en = 1'b1;
        if (up_less) begin
          wr_data = rd_a_r;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= heap_mem[rd_a_addr];
    rd_b_r <= heap_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spc_pkg::H_IDLE;
      fill_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      case (state_r)
        spc_pkg::H_IDLE: begin
          if (req.start) begin
            if (!req.push) begin
              fill_r <= fill_r - HW'(1);
            end else if (push_ok) begin
              pos_r       <= fill_r;
              fill_r      <= fill_r + HW'(1);
              item_key_r  <= push_key;
              item_node_r <= push_node;
            end else begin
              done_r <= 1'b1;
            end
          end
        end
        spc_pkg::H_POP_RD: begin
          out_key_r   <= a_key;
          out_node_r  <= a_node;
          item_key_r  <= b_key;
          item_node_r <= b_node;
          pos_r       <= '0;
          done_r      <= (fill_r == '0);
        end
        spc_pkg::H_DN_CMP: begin
          if (take_r) begin
            pos_r <= child_r[HW-1:0];
          end else if (take_l) begin
            pos_r <= child_l[HW-1:0];
          end else begin
            done_r <= 1'b1;
          end
        end
        spc_pkg::H_UP_RD: begin
          done_r <= (pos_r == '0);
        end
        spc_pkg::H_UP_CMP: begin
          if (up_less) begin
            pos_r <= parent;
          end else begin
            done_r <= 1'b1;
          end
        end
        default: begin
          done_r <= 1'b0;
        end
      endcase
    end
  end

  assign rsp.busy  = state_r != spc_pkg::H_IDLE;
  assign rsp.done  = done_r;
  assign rsp.empty = fill_r == '0;
  assign pop_key   = out_key_r;
  assign pop_node  = out_node_r;

  `SPC_ASSERT_IMPLY(a_start_idle, clk, rst_n, req.start, state_r == spc_pkg::H_IDLE, "heap start while busy")
  `SPC_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, req.start && !req.push, fill_r != '0, "pop from empty heap")
  `SPC_ASSERT_IMPLY(a_done_idle, clk, rst_n, done_r, state_r == spc_pkg::H_IDLE, "heap done while busy")
  `SPC_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= HW'(HDEPTH), "heap fill overflow")

endmodule

>>> rtl/shortest_path_counter.sv
// Shortest path counter: arc store, per-vertex results and Dijkstra sequencer.
// After reset a clearing pass over all MAX_VERTICES vertices runs with in_ready low.
// A run clears the vertex table, then pops vertices, scans their arcs and pushes improved distances.
// One transaction is in work at a time; the next is accepted while a result waits.
// Reset is synchronous and active low; the arc and heap memories are not cleared.
`timescale 1ns / 1ps
`include "shortest_path_counter_assert.svh"
module shortest_path_counter #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_ARCS     = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  spc_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output spc_pkg::out_item_t       out_data,
  input  logic                     cfg_wr_en,
  input  logic [spc_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW   = $clog2(MAX_ARCS);
  localparam int LW   = $clog2(MAX_ARCS + 1);
  localparam int LW1  = LW + 1;
  localparam int VCW  = ((VW + 1) > spc_pkg::CFG_W) ? (VW + 1) : spc_pkg::CFG_W;
  localparam int WW   = spc_pkg::WEIGHT_W;
  localparam int DW   = spc_pkg::DIST_W;
  localparam int ARCW = VW + WW + LW;
  localparam logic [LW-1:0] EMPTY = LW'(MAX_ARCS);

  spc_pkg::top_state_t state_r, state_nxt;
  logic [spc_pkg::CFG_W-1:0] vertex_count_r;
  spc_pkg::in_item_t  item_r;
  spc_pkg::out_item_t resp_r;
  spc_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic [LW-1:0]      arc_fill_r;
  logic [VW-1:0]      sweep_cnt_r;
  logic               sweep_head_r, sweep_vert_r;
  logic [DW-1:0]      dist_u_r, nd_r;
  logic [VW-1:0]      node_u_r, v_r;
  logic [spc_pkg::CNT_W-1:0] cnt_u_r;
  logic [LW-1:0]      arc_ptr_r;

  logic [LW-1:0]       head_mem [MAX_VERTICES];
  logic [ARCW-1:0]     arc_mem [MAX_ARCS];
  spc_pkg::vert_ent_t  vert_mem [MAX_VERTICES];
  logic [LW-1:0]       head_rd_r;
  logic [ARCW-1:0]     arc_rd_r;
  spc_pkg::vert_ent_t  vert_rd_r;

  logic                head_we;
  logic [VW-1:0]       head_waddr, head_raddr;
  logic [LW-1:0]       head_wdata;
  logic                arc_we;
  logic [AW-1:0]       arc_waddr, arc_raddr;
  logic [ARCW-1:0]     arc_wdata;
  logic                vert_we;
  logic [VW-1:0]       vert_waddr, vert_raddr;
  spc_pkg::vert_ent_t  vert_wdata, sweep_init;

  spc_pkg::heap_req_t  heap_req;
  spc_pkg::heap_rsp_t  heap_rsp;
  logic [DW-1:0]       push_key, hp_key;
  logic [VW-1:0]       push_node, hp_node;

  logic [VCW-1:0]      vc_eff;
  logic                first_bad, second_bad, arcs_full, sweep_last, out_free;
  logic [VW-1:0]       va, vb;
  logic [VW-1:0]       arc_tgt;
  logic [WW-1:0]       arc_len;
  logic [LW-1:0]       arc_lnk;
  logic                nd_less, nd_eq;
  logic [spc_pkg::CNT_W-1:0] cnt_sum;

  assign vc_eff = (VCW'(vertex_count_r) > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                               : VCW'(vertex_count_r);
  assign first_bad  = VCW'(item_r.first_vertex) >= vc_eff;
  assign second_bad = VCW'(item_r.second_vertex) >= vc_eff;
  assign arcs_full  = (LW1'(arc_fill_r) + LW1'(2)) > LW1'(MAX_ARCS);
  assign va         = VW'(item_r.first_vertex);
  assign vb         = VW'(item_r.second_vertex);
  assign sweep_last = sweep_cnt_r == VW'(MAX_VERTICES - 1);
  assign out_free   = !out_valid_r || out_ready;
  assign arc_tgt    = arc_rd_r[ARCW-1 -: VW];
  assign arc_len    = arc_rd_r[LW +: WW];
  assign arc_lnk    = arc_rd_r[LW-1:0];
  assign nd_less    = nd_r < vert_rd_r.best_dist;
  assign nd_eq      = nd_r == vert_rd_r.best_dist;
  assign cnt_sum    = spc_pkg::mod_add(vert_rd_r.count, cnt_u_r);

  always_comb begin
    if (sweep_vert_r && !sweep_head_r && (sweep_cnt_r == va)) begin
      sweep_init = '{best_dist: '0, count: spc_pkg::CNT_W'(1), settled: 1'b0};
    end else begin
      sweep_init = '{best_dist: spc_pkg::NO_PATH, count: '0, settled: 1'b0};
    end
  end

  spc_heap #(
    .MAX_ARCS (MAX_ARCS),
    .NODE_W   (VW)
  ) u_heap (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (heap_req),
    .push_key  (push_key),
    .push_node (push_node),
    .rsp       (heap_rsp),
    .pop_key   (hp_key),
    .pop_node  (hp_node)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spc_pkg::S_SWEEP: begin
        if (sweep_last) begin
          if (sweep_vert_r && !sweep_head_r) begin
            state_nxt = spc_pkg::S_RUN_PUSH;
          end else if (sweep_vert_r && sweep_head_r) begin
            state_nxt = spc_pkg::S_IDLE;
          end else begin
            state_nxt = spc_pkg::S_RESP;
          end
        end
      end
      spc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = spc_pkg::S_DECODE;
        end
      end
      spc_pkg::S_DECODE: begin
        case (item_r.func)
          spc_pkg::FUNC_ADD: begin
            state_nxt = (first_bad || second_bad || arcs_full) ? spc_pkg::S_RESP
                                                                : spc_pkg::S_ADD_WA;
          end
          spc_pkg::FUNC_RUN:   state_nxt = first_bad ? spc_pkg::S_RESP : spc_pkg::S_SWEEP;
          spc_pkg::FUNC_QUERY: state_nxt = first_bad ? spc_pkg::S_RESP : spc_pkg::S_QRY;
          default:             state_nxt = spc_pkg::S_SWEEP;
        endcase
      end
      spc_pkg::S_ADD_WA:   state_nxt = spc_pkg::S_ADD_RB;
      spc_pkg::S_ADD_RB:   state_nxt = spc_pkg::S_ADD_WB;
      spc_pkg::S_ADD_WB:   state_nxt = spc_pkg::S_RESP;
      spc_pkg::S_QRY:      state_nxt = spc_pkg::S_RESP;
      spc_pkg::S_RUN_PUSH: state_nxt = spc_pkg::S_PUSH0_WAIT;
      spc_pkg::S_PUSH0_WAIT: begin
        if (heap_rsp.done) begin
          state_nxt = spc_pkg::S_POP;
        end
      end
      spc_pkg::S_POP: begin
        state_nxt = heap_rsp.empty ? spc_pkg::S_RESP : spc_pkg::S_POP_WAIT;
      end
      spc_pkg::S_POP_WAIT: begin
        if (heap_rsp.done) begin
          state_nxt = spc_pkg::S_CHK_U;
        end
      end
      spc_pkg::S_CHK_U: begin
        state_nxt = vert_rd_r.settled ? spc_pkg::S_POP : spc_pkg::S_HEAD;
      end
      spc_pkg::S_HEAD: state_nxt = spc_pkg::S_ARC;
      spc_pkg::S_ARC: begin
        state_nxt = (arc_ptr_r == EMPTY) ? spc_pkg::S_POP : spc_pkg::S_ARC_D;
      end
      spc_pkg::S_ARC_D: state_nxt = spc_pkg::S_RELAX;
      spc_pkg::S_RELAX: begin
        state_nxt = nd_less ? spc_pkg::S_PUSH_WAIT : spc_pkg::S_ARC;
      end
      spc_pkg::S_PUSH_WAIT: begin
        if (heap_rsp.done) begin
          state_nxt = spc_pkg::S_ARC;
        end
      end
      spc_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = spc_pkg::S_IDLE;
        end
      end
      default: state_nxt = spc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_we    = 1'b0;
    head_waddr = va;
    head_wdata = arc_fill_r;
    head_raddr = va;
    arc_we     = 1'b0;
    arc_waddr  = arc_fill_r[AW-1:0];
    arc_wdata  = {vb, item_r.edge_weight, head_rd_r};
    arc_raddr  = arc_ptr_r[AW-1:0];
    vert_we    = 1'b0;
    vert_waddr = v_r;
    vert_wdata = '{best_dist: nd_r, count: cnt_u_r, settled: vert_rd_r.settled};
    vert_raddr = va;
    heap_req   = '0;
    push_key   = nd_r;
    push_node  = v_r;
    case (state_r)
      spc_pkg::S_SWEEP: begin
        head_we    = sweep_head_r;
        head_waddr = sweep_cnt_r;
        head_wdata = EMPTY;
        vert_we    = sweep_vert_r;
        vert_waddr = sweep_cnt_r;
        vert_wdata = sweep_init;
      end
      spc_pkg::S_ADD_WA: begin
        arc_we  = 1'b1;
        head_we = 1'b1;
      end
      spc_pkg::S_ADD_RB: begin
        head_raddr = vb;
      end
      spc_pkg::S_ADD_WB: begin
        arc_we     = 1'b1;
        arc_wdata  = {va, item_r.edge_weight, head_rd_r};
        head_we    = 1'b1;
        head_waddr = vb;
      end
      spc_pkg::S_RUN_PUSH: begin
        heap_req.start = 1'b1;
        heap_req.push  = 1'b1;
        push_key       = '0;
        push_node      = va;
      end
      spc_pkg::S_POP: begin
        heap_req.start = !heap_rsp.empty;
      end
      spc_pkg::S_POP_WAIT: begin
        vert_raddr = hp_node;
      end
      spc_pkg::S_CHK_U: begin
        vert_we    = !vert_rd_r.settled;
        vert_waddr = node_u_r;
        vert_wdata = '{best_dist: vert_rd_r.best_dist, count: vert_rd_r.count, settled: 1'b1};
        head_raddr = node_u_r;
      end
      spc_pkg::S_ARC_D: begin
        vert_raddr = arc_tgt;
      end
      spc_pkg::S_RELAX: begin
        if (nd_less) begin
          vert_we        = 1'b1;
          heap_req.start = 1'b1;
          heap_req.push  = 1'b1;
        end else if (nd_eq) begin
          vert_we    = 1'b1;
          vert_wdata = '{best_dist: vert_rd_r.best_dist, count: cnt_sum,
                         settled: vert_rd_r.settled};
        end
      end
      default: begin
        head_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_r <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (arc_we) begin
      arc_mem[arc_waddr] <= arc_wdata;
    end
    arc_rd_r <= arc_mem[arc_raddr];
  end

  always_ff @(posedge clk) begin
    if (vert_we) begin
      vert_mem[vert_waddr] <= vert_wdata;
    end
    vert_rd_r <= vert_mem[vert_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= spc_pkg::S_SWEEP;
      vertex_count_r <= 11'd1024;
      arc_fill_r     <= '0;
      sweep_cnt_r    <= '0;
      sweep_head_r   <= 1'b1;
      sweep_vert_r   <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        vertex_count_r <= cfg_wr_data;
      end
      if ((state_r == spc_pkg::S_RESP) && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= resp_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        spc_pkg::S_SWEEP: begin
          sweep_cnt_r <= sweep_cnt_r + VW'(1);
          if (sweep_last) begin
            sweep_cnt_r  <= '0;
            sweep_head_r <= 1'b0;
            sweep_vert_r <= 1'b0;
          end
        end
        spc_pkg::S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
          end
        end
        spc_pkg::S_DECODE: begin
          resp_r <= '{status: spc_pkg::STATUS_OK, distance: '0, path_count: '0,
                      reachable: 1'b0};
          case (item_r.func)
            spc_pkg::FUNC_ADD: begin
              if (first_bad || second_bad) begin
                resp_r.status <= spc_pkg::STATUS_RANGE;
              end else if (arcs_full) begin
                resp_r.status <= spc_pkg::STATUS_FULL;
              end
            end
            spc_pkg::FUNC_RUN: begin
              if (first_bad) begin
                resp_r.status <= spc_pkg::STATUS_RANGE;
              end else begin
                sweep_vert_r <= 1'b1;
              end
            end
            spc_pkg::FUNC_QUERY: begin
              if (first_bad) begin
                resp_r.status   <= spc_pkg::STATUS_RANGE;
                resp_r.distance <= spc_pkg::NO_PATH;
              end
            end
            default: begin
              arc_fill_r   <= '0;
              sweep_head_r <= 1'b1;
            end
          endcase
        end
        spc_pkg::S_ADD_WA, spc_pkg::S_ADD_WB: begin
          arc_fill_r <= arc_fill_r + LW'(1);
        end
        spc_pkg::S_QRY: begin
          resp_r.distance   <= vert_rd_r.best_dist;
          resp_r.path_count <= vert_rd_r.count;
          resp_r.reachable  <= vert_rd_r.best_dist != spc_pkg::NO_PATH;
        end
        spc_pkg::S_POP_WAIT: begin
          if (heap_rsp.done) begin
            dist_u_r <= hp_key;
            node_u_r <= hp_node;
          end
        end
        spc_pkg::S_CHK_U: begin
          cnt_u_r <= vert_rd_r.count;
        end
        spc_pkg::S_HEAD: begin
          arc_ptr_r <= head_rd_r;
        end
        spc_pkg::S_ARC_D: begin
          nd_r      <= dist_u_r + DW'(arc_len);
          v_r       <= arc_tgt;
          arc_ptr_r <= arc_lnk;
        end
        spc_pkg::S_RELAX: begin
          if ((v_r == node_u_r) && !nd_less && nd_eq) begin
            cnt_u_r <= cnt_sum;
          end
        end
        default: begin
          arc_fill_r <= arc_fill_r;
        end
      endcase
    end
  end

  assign in_ready  = state_r == spc_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SPC_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, arc_fill_r <= EMPTY, "arc fill overflow")
  `SPC_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_r == spc_pkg::S_DECODE, "accepted transaction not decoded")
  `SPC_ASSERT_IMPLY(a_heap_free, clk, rst_n, heap_req.start, !heap_rsp.busy, "heap started while busy")
  `SPC_ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid_r, (out_data_r.status == spc_pkg::STATUS_OK) || (out_data_r.status == spc_pkg::STATUS_FULL) || (out_data_r.status == spc_pkg::STATUS_RANGE), "bad status code")

endmodule
